// ----- rtl/core/ssbt_pkg.sv -----
package ssbt_pkg;

	localparam int unsigned WaitW  = 16;
	localparam int unsigned QuietW = 24;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned CountW = 4;
	localparam int unsigned AddrW  = 3;
	localparam int unsigned DataW  = 32;

	localparam logic [WaitW-1:0]  WaitMax      = '1;
	localparam logic [QuietW-1:0] QuietMax     = '1;
	localparam logic [CountW-1:0] BitsPerByte  = CountW'(8);
	localparam logic [WaitW-1:0]  TimeoutReset = WaitW'(1000);
	localparam logic [QuietW-1:0] IdleReset    = QuietW'(1000);

	// Command codes carried by the command field.
	localparam logic CmdTick  = 1'b0;
	localparam logic CmdStart = 1'b1;

	// Register index taken from the word address.
	localparam logic RegTimeout = 1'b0;
	localparam logic RegIdle    = 1'b1;

	typedef struct packed {
		logic             command;
		logic [ByteW-1:0] send_byte;
		logic             sclk;
		logic             miso;
	} item_t;

	typedef struct packed {
		logic             mosi;
		logic             busy_res;
		logic             done_res;
		logic             timed_out;
		logic [ByteW-1:0] received;
		logic             idle;
	} result_t;

	typedef struct packed {
		logic [WaitW-1:0]  timeout_ticks;
		logic [QuietW-1:0] idle_ticks;
	} cfg_t;

endpackage

// ----- rtl/core/serial_slave_byte_transfer.sv -----
// Serial slave byte exchange, MSB first, clocked by an external master.
// Every input transaction is one sampling tick of the sclk and miso pins,
// or a start command that loads send_byte; the transfer runs from the next
// tick. Each input transaction yields exactly one result transaction that
// carries the driven mosi level, busy, done, timeout, the received byte and
// the idle flag.
// Channels: item_valid/item_ready for input, res_valid/res_ready for
// results. The APB port holds timeout_ticks (address 0) and idle_ticks
// (address 4); pready is always high and writes are expected only while
// no transaction is in flight.
// Throughput is one transaction per cycle while the result side does not
// stall. A transaction accepted at an edge lands in the input register, is
// processed by the engine and written to the result register when it moves
// on, and its result is then offered; the engine's state update sets the rate.
// If the receiver stalls, the result register holds; the input register
// still takes one more transaction, after which item_ready drops until the
// result is taken.
// Reset clears all transfer state, the valid flags and restores both
// configuration registers to 1000.
module serial_slave_byte_transfer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic                        command,
	input  logic [ssbt_pkg::ByteW-1:0]  send_byte,
	input  logic                        sclk,
	input  logic                        miso,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic                        mosi,
	output logic                        busy_res,
	output logic                        done_res,
	output logic                        timed_out,
	output logic [ssbt_pkg::ByteW-1:0]  received,
	output logic                        idle,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ssbt_pkg::AddrW-1:0]  paddr,
	input  logic [ssbt_pkg::DataW-1:0]  pwdata,
	output logic [ssbt_pkg::DataW-1:0]  prdata,
	output logic                        pready
);
	import ssbt_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_next;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;

	ssbt_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The held item moves on whenever the result register is free or is
	// being emptied in this cycle; the engine state advances with it.
	assign advance    = valid_s1 && (!valid_s2 || res_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1.command   <= command;
			item_s1.send_byte <= send_byte;
			item_s1.sclk      <= sclk;
			item_s1.miso      <= miso;
		end
	end

	ssbt_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || res_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign res_valid = valid_s2;
	assign mosi      = res_s2.mosi;
	assign busy_res  = res_s2.busy_res;
	assign done_res  = res_s2.done_res;
	assign timed_out = res_s2.timed_out;
	assign received  = res_s2.received;
	assign idle      = res_s2.idle;

	// A transfer cannot both complete and abort on the same tick.
	a_done_xor_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.done_res && res_s2.timed_out))
		else $error("done and timeout reported together");

	// A completed byte always ends the transfer.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.done_res) |-> !res_s2.busy_res)
		else $error("busy still set on completion");

	// The received byte is only shown with done.
	a_received_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.done_res) |-> (res_s2.received == '0))
		else $error("received byte without done");

	// An empty input register always accepts.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> item_ready)
		else $error("input stalled while empty");

	// A stall on the result side keeps the held item in place.
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !res_ready) |=> valid_s1 && $stable(item_s1))
		else $error("held item lost during stall");

endmodule

// ----- rtl/core/ssbt_cfg_regs.sv -----
module ssbt_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ssbt_pkg::AddrW-1:0]   paddr,
	input  logic [ssbt_pkg::DataW-1:0]   pwdata,
	output logic [ssbt_pkg::DataW-1:0]   prdata,
	output logic                         pready,
	output ssbt_pkg::cfg_t               cfg
);
	import ssbt_pkg::*;

	logic [WaitW-1:0]  timeout_q;
	logic [QuietW-1:0] idle_q;
	logic              wr_en;
	logic              reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TimeoutReset;
			idle_q    <= IdleReset;
		end else if (wr_en) begin
			case (reg_idx)
				RegTimeout: timeout_q <= pwdata[WaitW-1:0];
				RegIdle:    idle_q    <= pwdata[QuietW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			RegTimeout: prdata = DataW'(timeout_q);
			RegIdle:    prdata = DataW'(idle_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg.timeout_ticks = timeout_q;
	assign cfg.idle_ticks    = idle_q;

endmodule

// ----- rtl/core/ssbt_engine.sv -----
module ssbt_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  ssbt_pkg::item_t   item,
	input  ssbt_pkg::cfg_t    cfg,
	output ssbt_pkg::result_t result
);
	import ssbt_pkg::*;

	logic [ByteW-1:0]  tx_shift_q, tx_shift_d;
	logic [ByteW-1:0]  rx_shift_q, rx_shift_d;
	logic [CountW-1:0] bits_left_q, bits_left_d;
	logic              wait_high_q, wait_high_d;
	logic              active_q, active_d;
	logic [WaitW-1:0]  wait_timer_q, wait_timer_d;
	logic [QuietW-1:0] quiet_timer_q, quiet_timer_d;
	logic              last_sclk_q;
	logic              last_sclk_valid_q;
	logic              mosi_q, mosi_d;
	logic              done, aborted, level_seen, expired, sclk_edge;

	always_comb begin
		tx_shift_d   = tx_shift_q;
		rx_shift_d   = rx_shift_q;
		bits_left_d  = bits_left_q;
		wait_high_d  = wait_high_q;
		active_d     = active_q;
		wait_timer_d = wait_timer_q;
		mosi_d       = mosi_q;
		done         = 1'b0;
		aborted      = 1'b0;
		level_seen   = wait_high_q ? item.sclk : !item.sclk;
		expired      = wait_timer_q >= cfg.timeout_ticks;

		if (item.command == CmdStart) begin
			tx_shift_d   = item.send_byte;
			rx_shift_d   = '0;
			bits_left_d  = BitsPerByte;
			wait_high_d  = 1'b0;
			wait_timer_d = '0;
			active_d     = 1'b1;
		end else if (active_q) begin
			if (level_seen) begin
				wait_timer_d = '0;
				wait_high_d  = !wait_high_q;
				if (!wait_high_q) begin
					mosi_d     = tx_shift_q[ByteW-1];
					tx_shift_d = {tx_shift_q[ByteW-2:0], 1'b0};
				end else begin
					rx_shift_d = {rx_shift_q[ByteW-2:0], item.miso};
					if (bits_left_q != '0)
						bits_left_d = bits_left_q - CountW'(1);
					if (bits_left_d == '0) begin
						done     = 1'b1;
						active_d = 1'b0;
					end
				end
			end else if (expired) begin
				aborted      = 1'b1;
				active_d     = 1'b0;
				bits_left_d  = '0;
				wait_high_d  = 1'b0;
				wait_timer_d = '0;
			end else if (wait_timer_q != WaitMax) begin
				wait_timer_d = wait_timer_q + WaitW'(1);
			end
		end

		sclk_edge = last_sclk_valid_q && (item.sclk != last_sclk_q);
		if (sclk_edge || done)
			quiet_timer_d = '0;
		else if (quiet_timer_q != QuietMax)
			quiet_timer_d = quiet_timer_q + QuietW'(1);
		else
			quiet_timer_d = quiet_timer_q;

		result.mosi      = mosi_d;
		result.busy_res  = active_d;
		result.done_res  = done;
		result.timed_out = aborted;
		result.received  = done ? rx_shift_d : '0;
		result.idle      = quiet_timer_d >= cfg.idle_ticks;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_shift_q        <= '0;
			rx_shift_q        <= '0;
			bits_left_q       <= '0;
			wait_high_q       <= 1'b0;
			active_q          <= 1'b0;
			wait_timer_q      <= '0;
			quiet_timer_q     <= '0;
			last_sclk_q       <= 1'b0;
			last_sclk_valid_q <= 1'b0;
			mosi_q            <= 1'b0;
		end else if (step) begin
			tx_shift_q        <= tx_shift_d;
			rx_shift_q        <= rx_shift_d;
			bits_left_q       <= bits_left_d;
			wait_high_q       <= wait_high_d;
			active_q          <= active_d;
			wait_timer_q      <= wait_timer_d;
			quiet_timer_q     <= quiet_timer_d;
			last_sclk_q       <= item.sclk;
			last_sclk_valid_q <= 1'b1;
			mosi_q            <= mosi_d;
		end
	end

endmodule
